### src/pss_pkg.sv
`timescale 1ns / 1ps
package pss_pkg;

   // build defaults for the top-level parameters
   localparam int NUM_SERVERS_DEF = 2;
   localparam int NUM_CLASSES_DEF = 3;

   // classes shown on the result beat and fed by the arrival mask
   localparam int OUT_CLASSES = 3;
   localparam int MASK_W      = 3;

   localparam int CNT_W  = 32;
   localparam int WAIT_W = 8;
   localparam int TICK_W = 16;
   localparam int SCLS_W = 2;
   localparam int VIC_W  = 3;

   localparam logic [SCLS_W-1:0] SERVER_IDLE = 2'd3;
   localparam logic [CNT_W-1:0]  CNT_MAX     = '1;

   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 224;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic [WAIT_W-1:0] QUEUE_LIMIT_RST       = 8'd6;
   localparam logic [WAIT_W-1:0] PREEMPT_THRESHOLD_RST = 8'd3;
   localparam logic [TICK_W-1:0] SERVICE_TICKS_A_RST   = 16'd70;
   localparam logic [TICK_W-1:0] SERVICE_TICKS_B_RST   = 16'd100;

   typedef enum logic [1:0] {
      REG_QUEUE_LIMIT       = 2'd0,
      REG_PREEMPT_THRESHOLD = 2'd1,
      REG_SERVICE_TICKS_A   = 2'd2,
      REG_SERVICE_TICKS_B   = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic [WAIT_W-1:0] queue_limit;
      logic [WAIT_W-1:0] preempt_threshold;
      logic [TICK_W-1:0] service_ticks_a;
      logic [TICK_W-1:0] service_ticks_b;
   } cfg_type;

   // queue admission decision
   typedef struct packed {
      logic             admit;
      logic             push;
      logic [VIC_W-1:0] victim;
   } enq_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FREE,
      ST_ARRIVE,
      ST_LOAD,
      ST_PREEMPT,
      ST_REQUEUE,
      ST_DONE
   } state_type;

   function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
      return (v == CNT_MAX) ? v : v + 1'b1;
   endfunction

endpackage

### src/pss_csr.sv
`timescale 1ns / 1ps
module pss_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [pss_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [pss_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [pss_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                            pready,
   output pss_pkg::cfg_type                cfg
);
   import pss_pkg::*;

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type reg_idx;
   logic          wr_en;

   assign reg_idx = reg_index_type'(paddr[CSR_ADDR_W-1:2]);
   assign wr_en   = psel & penable & pwrite;
   assign pready  = 1'b1;
   assign cfg     = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_QUEUE_LIMIT:       cfg_in.queue_limit       = pwdata[WAIT_W-1:0];
            REG_PREEMPT_THRESHOLD: cfg_in.preempt_threshold = pwdata[WAIT_W-1:0];
            REG_SERVICE_TICKS_A:   cfg_in.service_ticks_a   = pwdata[TICK_W-1:0];
            REG_SERVICE_TICKS_B:   cfg_in.service_ticks_b   = pwdata[TICK_W-1:0];
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_QUEUE_LIMIT:       prdata = CSR_DATA_W'(cfg_ff.queue_limit);
         REG_PREEMPT_THRESHOLD: prdata = CSR_DATA_W'(cfg_ff.preempt_threshold);
         REG_SERVICE_TICKS_A:   prdata = CSR_DATA_W'(cfg_ff.service_ticks_a);
         REG_SERVICE_TICKS_B:   prdata = CSR_DATA_W'(cfg_ff.service_ticks_b);
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.queue_limit       <= QUEUE_LIMIT_RST;
         cfg_ff.preempt_threshold <= PREEMPT_THRESHOLD_RST;
         cfg_ff.service_ticks_a   <= SERVICE_TICKS_A_RST;
         cfg_ff.service_ticks_b   <= SERVICE_TICKS_B_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

### src/pss_queue.sv
`timescale 1ns / 1ps
module pss_queue #(
   parameter int NUM_CLASSES = pss_pkg::NUM_CLASSES_DEF,
   parameter int CLS_W       = $clog2(NUM_CLASSES)
) (
   input  logic [pss_pkg::WAIT_W-1:0] wait_cnt [NUM_CLASSES],
   input  logic [pss_pkg::WAIT_W-1:0] total,
   input  logic [pss_pkg::WAIT_W-1:0] limit,
   input  logic [CLS_W-1:0]           cls,
   output pss_pkg::enq_type           res
);
   import pss_pkg::*;

   // admit while room is left, else push out the lowest-class waiter below cls if any
   always_comb begin
      res       = '0;
      res.admit = (total < limit);
      for (int c = 0; c < NUM_CLASSES; c++) begin
         if (c > int'(cls) && wait_cnt[c] != '0) begin
            res.push   = 1'b1;
            res.victim = VIC_W'(c);
         end
      end
      if (res.admit) begin
         res.push = 1'b0;
      end
   end

endmodule

### src/pss_engine.sv
`timescale 1ns / 1ps
module pss_engine #(
   parameter int NUM_SERVERS = pss_pkg::NUM_SERVERS_DEF,
   parameter int NUM_CLASSES = pss_pkg::NUM_CLASSES_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  pss_pkg::cfg_type               cfg,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [pss_pkg::MASK_W-1:0]     arrival_mask,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [pss_pkg::RSP_DATA_W-1:0] rsp_data
);
   import pss_pkg::*;

   localparam int CLS_W = $clog2(NUM_CLASSES);
   localparam int SRV_W = (NUM_SERVERS > 1) ? $clog2(NUM_SERVERS) : 1;
   localparam logic [SRV_W-1:0] SRV_LAST = SRV_W'(NUM_SERVERS - 1);
   localparam logic [1:0]       ARR_LAST = 2'(OUT_CLASSES - 1);
   localparam int PAD_W = RSP_DATA_W - (6 * CNT_W + 3 * WAIT_W + 2 * SCLS_W);

   state_type               state_ff, state_in;
   logic [SRV_W-1:0]        srv_ff, srv_in;
   logic [1:0]              cix_ff, cix_in;
   logic [MASK_W-1:0]       mask_ff, mask_in;
   logic [NUM_SERVERS-1:0]  busy_ff, busy_in;
   logic [CLS_W-1:0]        scls_ff [NUM_SERVERS];
   logic [CLS_W-1:0]        scls_in [NUM_SERVERS];
   logic [TICK_W-1:0]       ticks_ff [NUM_SERVERS];
   logic [TICK_W-1:0]       ticks_in [NUM_SERVERS];
   logic [WAIT_W-1:0]       wait_ff [NUM_CLASSES];
   logic [WAIT_W-1:0]       wait_in [NUM_CLASSES];
   logic [WAIT_W-1:0]       tot_ff, tot_in;
   logic [CNT_W-1:0]        arr_ff [NUM_CLASSES];
   logic [CNT_W-1:0]        arr_in [NUM_CLASSES];
   logic [CNT_W-1:0]        ref_ff [NUM_CLASSES];
   logic [CNT_W-1:0]        ref_in [NUM_CLASSES];
   logic [CLS_W-1:0]        worst_ff, worst_in;
   logic                    out_valid_ff, out_valid_in;
   logic [RSP_DATA_W-1:0]   out_data_ff, out_data_in;

   logic                    free_found;
   logic [SRV_W-1:0]        free_idx;
   logic                    hi_found;
   logic [CLS_W-1:0]        hi_cls;
   logic                    vic_found;
   logic [SRV_W-1:0]        vic_idx;
   logic [CLS_W-1:0]        vic_cls;
   logic [CLS_W-1:0]        arr_cls;
   logic                    arr_hit;
   logic [CLS_W-1:0]        q_cls;
   logic [CLS_W-1:0]        q_victim;
   logic                    do_enq;
   enq_type                 enq;

   logic [CNT_W-1:0]        snap_arr [OUT_CLASSES];
   logic [CNT_W-1:0]        snap_ref [OUT_CLASSES];
   logic [WAIT_W-1:0]       snap_wait [OUT_CLASSES];
   logic [SCLS_W-1:0]       snap_srv [2];
   logic [RSP_DATA_W-1:0]   snap;

   function automatic logic [TICK_W-1:0] dur_of(input logic [SRV_W-1:0] s,
                                                  input cfg_type c);
      return (s == '0) ? c.service_ticks_a : c.service_ticks_b;
   endfunction

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   assign arr_cls  = CLS_W'(cix_ff);
   assign arr_hit  = mask_ff[cix_ff] && (32'(cix_ff) < NUM_CLASSES);
   assign q_cls    = (state_ff == ST_REQUEUE) ? worst_ff : arr_cls;
   assign q_victim = CLS_W'(enq.victim);

   pss_queue #(
      .NUM_CLASSES (NUM_CLASSES),
      .CLS_W       (CLS_W)
   ) u_queue (
      .wait_cnt (wait_ff),
      .total    (tot_ff),
      .limit    (cfg.queue_limit),
      .cls      (q_cls),
      .res      (enq)
   );

   // lowest idle server
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int s = 0; s < NUM_SERVERS; s++) begin
         if (!busy_ff[s] && !free_found) begin
            free_found = 1'b1;
            free_idx   = SRV_W'(s);
         end
      end
   end

   // highest non-empty class
   always_comb begin
      hi_found = 1'b0;
      hi_cls   = '0;
      for (int c = 0; c < NUM_CLASSES; c++) begin
         if (wait_ff[c] != '0 && !hi_found) begin
            hi_found = 1'b1;
            hi_cls   = CLS_W'(c);
         end
      end
   end

   // busy server with the lowest class, first index on a tie
   always_comb begin
      vic_found = 1'b0;
      vic_idx   = '0;
      vic_cls   = '0;
      for (int s = 0; s < NUM_SERVERS; s++) begin
         if (busy_ff[s] && (!vic_found || scls_ff[s] > vic_cls)) begin
            vic_found = 1'b1;
            vic_idx   = SRV_W'(s);
            vic_cls   = scls_ff[s];
         end
      end
   end

   for (genvar c = 0; c < OUT_CLASSES; c++) begin : g_snap
      if (c < NUM_CLASSES) begin : g_on
         assign snap_arr[c]  = arr_ff[c];
         assign snap_ref[c]  = ref_ff[c];
         assign snap_wait[c] = wait_ff[c];
      end else begin : g_off
         assign snap_arr[c]  = '0;
         assign snap_ref[c]  = '0;
         assign snap_wait[c] = '0;
      end
   end

   assign snap_srv[0] = busy_ff[0] ? SCLS_W'(scls_ff[0]) : SERVER_IDLE;
   if (NUM_SERVERS > 1) begin : g_srv_b
      assign snap_srv[1] = busy_ff[1] ? SCLS_W'(scls_ff[1]) : SERVER_IDLE;
   end else begin : g_no_srv_b
      assign snap_srv[1] = SERVER_IDLE;
   end

   assign snap = {{PAD_W{1'b0}}, snap_srv[1], snap_srv[0],
                  snap_wait[2], snap_wait[1], snap_wait[0],
                  snap_ref[2], snap_ref[1], snap_ref[0],
                  snap_arr[2], snap_arr[1], snap_arr[0]};

   always_comb begin
      state_in     = state_ff;
      srv_in       = srv_ff;
      cix_in       = cix_ff;
      mask_in      = mask_ff;
      busy_in      = busy_ff;
      scls_in      = scls_ff;
      ticks_in     = ticks_ff;
      wait_in      = wait_ff;
      tot_in       = tot_ff;
      arr_in       = arr_ff;
      ref_in       = ref_ff;
      worst_in     = worst_ff;
      out_valid_in = out_valid_ff & ~rsp_ready;
      out_data_in  = out_data_ff;
      do_enq       = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               mask_in  = arrival_mask;
               srv_in   = '0;
               state_in = ST_FREE;
            end
         end
         ST_FREE: begin
            // count down one server per cycle, release at the end of service
            if (busy_ff[srv_ff]) begin
               if (ticks_ff[srv_ff] <= TICK_W'(1)) begin
                  ticks_in[srv_ff] = '0;
                  busy_in[srv_ff]  = 1'b0;
               end else begin
                  ticks_in[srv_ff] = ticks_ff[srv_ff] - 1'b1;
               end
            end
            if (srv_ff == SRV_LAST) begin
               srv_in   = '0;
               cix_in   = '0;
               state_in = ST_ARRIVE;
            end else begin
               srv_in = srv_ff + 1'b1;
            end
         end
         ST_ARRIVE: begin
            if (arr_hit) begin
               arr_in[arr_cls] = sat_inc(arr_ff[arr_cls]);
               if (free_found) begin
                  busy_in[free_idx]  = 1'b1;
                  scls_in[free_idx]  = arr_cls;
                  ticks_in[free_idx] = dur_of(free_idx, cfg);
               end else begin
                  do_enq = 1'b1;
               end
            end
            if (cix_ff == ARR_LAST) begin
               state_in = ST_LOAD;
            end else begin
               cix_in = cix_ff + 1'b1;
            end
         end
         ST_LOAD: begin
            if (!busy_ff[srv_ff] && hi_found) begin
               wait_in[hi_cls]  = wait_ff[hi_cls] - 1'b1;
               tot_in           = tot_ff - 1'b1;
               busy_in[srv_ff]  = 1'b1;
               scls_in[srv_ff]  = hi_cls;
               ticks_in[srv_ff] = dur_of(srv_ff, cfg);
            end
            if (srv_ff == SRV_LAST) begin
               state_in = ST_PREEMPT;
            end else begin
               srv_in = srv_ff + 1'b1;
            end
         end
         ST_PREEMPT: begin
            if (wait_ff[0] >= cfg.preempt_threshold && hi_found && vic_found &&
                hi_cls < vic_cls) begin
               wait_in[hi_cls]   = wait_ff[hi_cls] - 1'b1;
               tot_in            = tot_ff - 1'b1;
               scls_in[vic_idx]  = hi_cls;
               ticks_in[vic_idx] = dur_of(vic_idx, cfg);
               worst_in          = vic_cls;
               state_in          = ST_REQUEUE;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_REQUEUE: begin
            do_enq   = 1'b1;
            state_in = ST_PREEMPT;
         end
         ST_DONE: begin
            // hold until the output register is free
            if (!out_valid_ff || rsp_ready) begin
               out_valid_in = 1'b1;
               out_data_in  = snap;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (do_enq) begin
         if (enq.admit) begin
            wait_in[q_cls] = wait_ff[q_cls] + 1'b1;
            tot_in         = tot_ff + 1'b1;
         end else if (enq.push) begin
            wait_in[q_victim] = wait_ff[q_victim] - 1'b1;
            wait_in[q_cls]    = wait_ff[q_cls] + 1'b1;
            ref_in[q_victim]  = sat_inc(ref_ff[q_victim]);
         end else begin
            ref_in[q_cls] = sat_inc(ref_ff[q_cls]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         busy_ff      <= '0;
         tot_ff       <= '0;
         out_valid_ff <= 1'b0;
         for (int s = 0; s < NUM_SERVERS; s++) begin
            ticks_ff[s] <= '0;
         end
         for (int c = 0; c < NUM_CLASSES; c++) begin
            wait_ff[c] <= '0;
            arr_ff[c]  <= '0;
            ref_ff[c]  <= '0;
         end
      end else begin
         state_ff     <= state_in;
         busy_ff      <= busy_in;
         tot_ff       <= tot_in;
         out_valid_ff <= out_valid_in;
         ticks_ff     <= ticks_in;
         wait_ff      <= wait_in;
         arr_ff       <= arr_in;
         ref_ff       <= ref_in;
      end
   end

   always_ff @(posedge clock) begin
      srv_ff      <= srv_in;
      cix_ff      <= cix_in;
      mask_ff     <= mask_in;
      scls_ff     <= scls_in;
      worst_ff    <= worst_in;
      out_data_ff <= out_data_in;
   end

endmodule

### src/priority_server_scheduler_pushout.sv
`timescale 1ns / 1ps
// The sequencer walks the servers twice, the three arrival classes once, and each
// preemption round through the shared queue unit; a result stall holds it in ST_DONE.
// A new input beat is taken only after the previous result has entered the output register.
// Reset is synchronous: counts clear, servers go idle, registers return to defaults.
module priority_server_scheduler_pushout #(
   parameter int NUM_SERVERS = pss_pkg::NUM_SERVERS_DEF,
   parameter int NUM_CLASSES = pss_pkg::NUM_CLASSES_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // [2:0] arrival_mask, [7:3] zero
   input  logic [pss_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // [31:0] arrived_hi, [63:32] arrived_mid, [95:64] arrived_lo,
   // [127:96] refused_hi, [159:128] refused_mid, [191:160] refused_lo,
   // [199:192] waiting_hi, [207:200] waiting_mid, [215:208] waiting_lo,
   // [217:216] server_a_class, [219:218] server_b_class, [223:220] zero
   output logic [pss_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [pss_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [pss_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [pss_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready
);
   import pss_pkg::*;

   cfg_type cfg;

   pss_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   pss_engine #(
      .NUM_SERVERS (NUM_SERVERS),
      .NUM_CLASSES (NUM_CLASSES)
   ) u_engine (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg),
      .req_valid    (req_tvalid),
      .req_ready    (req_tready),
      .arrival_mask (req_tdata[MASK_W-1:0]),
      .rsp_valid    (rsp_tvalid),
      .rsp_ready    (rsp_tready),
      .rsp_data     (rsp_tdata)
   );

endmodule

### src/pss_checker.sv
`timescale 1ns / 1ps
module pss_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tvalid,
   input logic                           req_tready,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [pss_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("block not idle after reset");

   a_busy_after_beat: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input taken again while a tick is in work");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result beat changed");

   // class 0 is never pushed out, so its refusals never pass its arrivals
   a_refused_hi: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[127:96] <= rsp_tdata[31:0])
      else $error("class 0 refusals exceed arrivals");

endmodule

bind priority_server_scheduler_pushout pss_checker u_pss_checker (.*);

### dv/pss_tick_scoreboard.sv
`timescale 1ns / 1ps
module pss_tick_scoreboard (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   input  logic                           req_tready,
   input  logic [pss_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   input  logic [pss_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [pss_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [pss_pkg::CSR_DATA_W-1:0] csr_pwdata,
   input  logic [pss_pkg::CSR_DATA_W-1:0] csr_prdata,
   input  logic                           csr_pready,
   output int                             error_count,
   output int                             pending_count
);
   import pss_pkg::*;

   localparam int NSRV = NUM_SERVERS_DEF;
   localparam int NCLS = NUM_CLASSES_DEF;

   typedef struct packed {
      logic [OUT_CLASSES-1:0][CNT_W-1:0]  arrived;
      logic [OUT_CLASSES-1:0][CNT_W-1:0]  refused;
      logic [OUT_CLASSES-1:0][WAIT_W-1:0] waiting;
      logic [SCLS_W-1:0]                  server_a;
      logic [SCLS_W-1:0]                  server_b;
   } tick_result_type;

   // scheduler state as the block should hold it
   logic [WAIT_W-1:0] waiting [NCLS];
   logic [SCLS_W-1:0] on_server [NSRV];
   logic [TICK_W-1:0] ticks_left [NSRV];
   logic [CNT_W-1:0]  arrivals [NCLS];
   logic [CNT_W-1:0]  refusals [NCLS];

   logic [WAIT_W-1:0] queue_limit;
   logic [WAIT_W-1:0] preempt_thr;
   logic [TICK_W-1:0] ticks_a;
   logic [TICK_W-1:0] ticks_b;

   tick_result_type pending_ticks [$];
   tick_result_type want_tick;
   tick_result_type got_tick;
   logic [CSR_DATA_W-1:0] want_rd;
   int errors = 0;
   int beat_no = 0;

   task automatic report_mismatch(input string msg);
      $display("[%0t] result beat %0d: %s", $time, beat_no, msg);
      errors++;
   endtask

   function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] v);
      return (&v) ? v : v + 1'b1;
   endfunction

   function automatic void clear_state();
      for (int c = 0; c < NCLS; c++) begin
         waiting[c]  = '0;
         arrivals[c] = '0;
         refusals[c] = '0;
      end
      for (int s = 0; s < NSRV; s++) begin
         on_server[s]  = SERVER_IDLE;
         ticks_left[s] = '0;
      end
      queue_limit = QUEUE_LIMIT_RST;
      preempt_thr = PREEMPT_THRESHOLD_RST;
      ticks_a     = SERVICE_TICKS_A_RST;
      ticks_b     = SERVICE_TICKS_B_RST;
   endfunction

   function automatic void begin_service(input int s, input int cls);
      on_server[s]  = SCLS_W'(cls);
      ticks_left[s] = (s == 0) ? ticks_a : ticks_b;
   endfunction

   // admit to the shared queue, push out the lowest lower class when full, or refuse
   function automatic void join_queue(input int cls);
      int total;
      total = 0;
      for (int c = 0; c < NCLS; c++)
         total += int'(waiting[c]);
      if (total < int'(queue_limit)) begin
         waiting[cls]++;
         return;
      end
      for (int c = NCLS - 1; c > cls; c--) begin
         if (waiting[c] != '0) begin
            waiting[c]--;
            refusals[c] = bump(refusals[c]);
            waiting[cls]++;
            return;
         end
      end
      refusals[cls] = bump(refusals[cls]);
   endfunction

   function automatic int first_waiting();
      for (int c = 0; c < NCLS; c++)
         if (waiting[c] != '0) return c;
      return -1;
   endfunction

   function automatic tick_result_type run_tick(input logic [MASK_W-1:0] mask);
      tick_result_type r;
      bit placed;
      int h;
      int victim;
      int worst;
      for (int s = 0; s < NSRV; s++) begin
         if (on_server[s] != SERVER_IDLE) begin
            if (ticks_left[s] <= 1) begin
               ticks_left[s] = '0;
               on_server[s]  = SERVER_IDLE;
            end else begin
               ticks_left[s]--;
            end
         end
      end
      for (int c = 0; c < MASK_W; c++) begin
         if (mask[c]) begin
            arrivals[c] = bump(arrivals[c]);
            placed = 1'b0;
            for (int s = 0; s < NSRV; s++) begin
               if (!placed && on_server[s] == SERVER_IDLE) begin
                  begin_service(s, c);
                  placed = 1'b1;
               end
            end
            if (!placed) join_queue(c);
         end
      end
      for (int s = 0; s < NSRV; s++) begin
         if (on_server[s] == SERVER_IDLE) begin
            h = first_waiting();
            if (h >= 0) begin
               waiting[h]--;
               begin_service(s, h);
            end
         end
      end
      // preempt the lowest class in service while enough class-0 jobs wait
      while (waiting[0] >= preempt_thr) begin
         h = first_waiting();
         victim = -1;
         worst = -1;
         for (int s = 0; s < NSRV; s++) begin
            if (on_server[s] != SERVER_IDLE && int'(on_server[s]) > worst) begin
               worst = int'(on_server[s]);
               victim = s;
            end
         end
         if (h < 0 || victim < 0 || h >= worst) break;
         waiting[h]--;
         begin_service(victim, h);
         join_queue(worst);
      end
      for (int c = 0; c < OUT_CLASSES; c++) begin
         r.arrived[c] = arrivals[c];
         r.refused[c] = refusals[c];
         r.waiting[c] = waiting[c];
      end
      r.server_a = on_server[0];
      r.server_b = (NSRV > 1) ? on_server[NSRV > 1 ? 1 : 0] : SERVER_IDLE;
      return r;
   endfunction

   function automatic tick_result_type unpack_rsp(input logic [RSP_DATA_W-1:0] d);
      tick_result_type r;
      for (int c = 0; c < OUT_CLASSES; c++) begin
         r.arrived[c] = d[CNT_W*c +: CNT_W];
         r.refused[c] = d[CNT_W*(OUT_CLASSES+c) +: CNT_W];
         r.waiting[c] = d[2*OUT_CLASSES*CNT_W + WAIT_W*c +: WAIT_W];
      end
      r.server_a = d[217:216];
      r.server_b = d[219:218];
      return r;
   endfunction

   function automatic logic [CSR_DATA_W-1:0] reg_value(input reg_index_type idx);
      case (idx)
         REG_QUEUE_LIMIT:       return CSR_DATA_W'(queue_limit);
         REG_PREEMPT_THRESHOLD: return CSR_DATA_W'(preempt_thr);
         REG_SERVICE_TICKS_A:   return CSR_DATA_W'(ticks_a);
         default:               return CSR_DATA_W'(ticks_b);
      endcase
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         clear_state();
         pending_ticks.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pready) begin
            if (csr_pwrite) begin
               case (reg_index_type'(csr_paddr[3:2]))
                  REG_QUEUE_LIMIT:       queue_limit = csr_pwdata[WAIT_W-1:0];
                  REG_PREEMPT_THRESHOLD: preempt_thr = csr_pwdata[WAIT_W-1:0];
                  REG_SERVICE_TICKS_A:   ticks_a     = csr_pwdata[TICK_W-1:0];
                  default:               ticks_b     = csr_pwdata[TICK_W-1:0];
               endcase
            end else begin
               want_rd = reg_value(reg_index_type'(csr_paddr[3:2]));
               if (csr_prdata !== want_rd)
                  report_mismatch($sformatf("register at %0h read %0h, want %0h",
                                            csr_paddr, csr_prdata, want_rd));
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            if (pending_ticks.size() == 0) begin
               report_mismatch("result beat with no tick outstanding");
            end else begin
               want_tick = pending_ticks.pop_front();
               got_tick  = unpack_rsp(rsp_tdata);
               for (int c = 0; c < OUT_CLASSES; c++) begin
                  if (got_tick.arrived[c] !== want_tick.arrived[c])
                     report_mismatch($sformatf("arrived class %0d got %0d want %0d", c,
                                               got_tick.arrived[c], want_tick.arrived[c]));
                  if (got_tick.refused[c] !== want_tick.refused[c])
                     report_mismatch($sformatf("refused class %0d got %0d want %0d", c,
                                               got_tick.refused[c], want_tick.refused[c]));
                  if (got_tick.waiting[c] !== want_tick.waiting[c])
                     report_mismatch($sformatf("waiting class %0d got %0d want %0d", c,
                                               got_tick.waiting[c], want_tick.waiting[c]));
               end
               if (got_tick.server_a !== want_tick.server_a)
                  report_mismatch($sformatf("server_a_class got %0d want %0d",
                                            got_tick.server_a, want_tick.server_a));
               if (got_tick.server_b !== want_tick.server_b)
                  report_mismatch($sformatf("server_b_class got %0d want %0d",
                                            got_tick.server_b, want_tick.server_b));
            end
            beat_no++;
         end
         if (req_tvalid && req_tready)
            pending_ticks.push_back(run_tick(req_tdata[MASK_W-1:0]));
      end
      pending_count <= pending_ticks.size();
      error_count   <= errors;
   end

endmodule

### dv/priority_server_scheduler_pushout_tb.sv
`timescale 1ns / 1ps
module priority_server_scheduler_pushout_tb;
   import pss_pkg::*;

   localparam int DRAIN_CYCLES = 40;
   localparam int PHASES       = 12;
   localparam int PHASE_TICKS  = 150;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   int error_count;
   int pending_count;
   bit idling = 1'b1;
   int load_pct = 50;

   priority_server_scheduler_pushout DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   pss_tick_scoreboard u_tick_scoreboard (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_prdata    (csr_prdata),
      .csr_pready    (csr_pready),
      .error_count   (error_count),
      .pending_count (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // result side: random stall bursts while idling is on
   initial begin
      rsp_tready <= 1'b0;
      repeat (8) @(posedge clock);
      forever begin
         if (idling && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   end

   task automatic send_tick(input logic [MASK_W-1:0] mask);
      if (idling && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_DATA_W-MASK_W){1'b0}}, mask};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // hold off until every tick has its result, then let the block settle
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_access(input reg_index_type idx, input bit wr,
                             input logic [CSR_DATA_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic read_all_regs();
      csr_access(REG_QUEUE_LIMIT, 1'b0, '0);
      csr_access(REG_PREEMPT_THRESHOLD, 1'b0, '0);
      csr_access(REG_SERVICE_TICKS_A, 1'b0, '0);
      csr_access(REG_SERVICE_TICKS_B, 1'b0, '0);
   endtask

   task automatic set_config(input logic [WAIT_W-1:0] limit, input logic [WAIT_W-1:0] thr,
                             input logic [TICK_W-1:0] svc_a, input logic [TICK_W-1:0] svc_b);
      csr_access(REG_QUEUE_LIMIT, 1'b1, CSR_DATA_W'(limit));
      csr_access(REG_PREEMPT_THRESHOLD, 1'b1, CSR_DATA_W'(thr));
      csr_access(REG_SERVICE_TICKS_A, 1'b1, CSR_DATA_W'(svc_a));
      csr_access(REG_SERVICE_TICKS_B, 1'b1, CSR_DATA_W'(svc_b));
      read_all_regs();
   endtask

   task automatic random_ticks(input int count);
      logic [MASK_W-1:0] mask;
      for (int i = 0; i < count; i++) begin
         for (int c = 0; c < MASK_W; c++)
            mask[c] = ($urandom_range(0, 99) < load_pct);
         send_tick(mask);
      end
   endtask

   function automatic logic [TICK_W-1:0] pick_service();
      if ($urandom_range(0, 3) == 0) return TICK_W'($urandom_range(17, 120));
      return TICK_W'($urandom_range(1, 16));
   endfunction

   initial begin
      logic [MASK_W-1:0] opening [19];
      opening = '{3'b000, 3'b001, 3'b010, 3'b100, 3'b111, 3'b111, 3'b111, 3'b111,
                  3'b111, 3'b111, 3'b111, 3'b111, 3'b001, 3'b001, 3'b011, 3'b101,
                  3'b110, 3'b000, 3'b111};
      reset       <= 1'b1;
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset defaults: long service fills the queue, pushes out and preempts
      read_all_regs();
      foreach (opening[i]) send_tick(opening[i]);
      drain();

      // zero service time, zero queue limit, threshold zero
      set_config(8'd0, 8'd0, 16'd0, 16'd0);
      send_tick(3'b111);
      send_tick(3'b111);
      send_tick(3'b100);
      send_tick(3'b000);
      send_tick(3'b111);
      drain();

      for (int p = 0; p < PHASES; p++) begin
         load_pct = $urandom_range(15, 95);
         case (p)
            0: begin
               set_config(8'd255, 8'd255, 16'hFFFF, 16'hFFFF);
               load_pct = 90;
            end
            1: set_config(8'd0, 8'd0, 16'd1, 16'd1);
            2: set_config(8'd255, 8'd0, pick_service(), pick_service());
            3: set_config(8'd1, 8'd1, pick_service(), pick_service());
            default: set_config(WAIT_W'($urandom_range(0, 12)), WAIT_W'($urandom_range(0, 6)),
                                pick_service(), pick_service());
         endcase
         random_ticks(PHASE_TICKS / 2);
         if (p % 4 == 1) drain();
         random_ticks(PHASE_TICKS - PHASE_TICKS / 2);
         drain();
      end

      // closing stretch at full rate on both sides
      idling = 1'b0;
      set_config(8'd5, 8'd2, 16'd9, 16'd13);
      load_pct = 60;
      random_ticks(PHASE_TICKS);
      drain();

      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
